/* rtl/nkts_pkg.sv */
// Shared constants, types and register indexes of the nearest-target selector.
package nkts_pkg;

   localparam int TARGET_SLOTS = 3;
   localparam int SLOT_IDX_W   = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
   localparam int COUNT_W      = $clog2(TARGET_SLOTS + 1);

   localparam int COORD_W    = 16;
   localparam int MAG_W      = 16;
   localparam int ID_W       = 16;
   localparam int RANGE_W    = 15;
   localparam int RANK_W     = 4;
   localparam int DIST_W     = 34;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_RANGE = 2'd2;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 15'd350;

   typedef logic [DIST_W-1:0] dist_type;

   // one pass of the shared squarer
   typedef struct packed {
      logic             en;
      logic             clear_acc;
      logic [MAG_W-1:0] operand;
   } sq_op_type;

   // control from the sequencer to the slot list
   typedef struct packed {
      logic                  insert;
      logic                  clear;
      logic [COUNT_W-1:0]    pos;
      logic [SLOT_IDX_W-1:0] rd_idx;
      logic [ID_W-1:0]       new_id;
      dist_type              new_dist;
   } slot_ctrl_type;

endpackage

/* rtl/nkts_ifs.sv */
// Handshake channels: candidate items, result items and register writes.
interface nkts_req_if;
   import nkts_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      point_valid;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic [ID_W-1:0]           point_id;
   logic                      frame_last;

   modport source (output valid, point_valid, point_x, point_y, point_id, frame_last,
                   input ready);
   modport sink   (input valid, point_valid, point_x, point_y, point_id, frame_last,
                   output ready);
endinterface

interface nkts_rsp_if;
   import nkts_pkg::*;
   logic              valid;
   logic              ready;
   logic              target_found;
   logic [ID_W-1:0]   target_id;
   logic [RANK_W-1:0] target_rank;
   logic              result_last;

   modport source (output valid, target_found, target_id, target_rank, result_last,
                   input ready);
   modport sink   (input valid, target_found, target_id, target_rank, result_last,
                   output ready);
endinterface

interface nkts_csr_if;
   import nkts_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/nkts_sq_unit.sv */
// Shared square-and-accumulate unit: acc = (clear ? 0 : acc) + operand^2.
module nkts_sq_unit
   import nkts_pkg::*;
(
   input  logic      clock,
   input  sq_op_type op,
   output dist_type  acc
);

   dist_type             acc_ff, acc_in;
   logic [2*MAG_W-1:0]   square;

   always_comb begin
      square = op.operand * op.operand;
      acc_in = (op.clear_acc ? '0 : acc_ff) + DIST_W'(square);
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* rtl/nkts_slot_list.sv */
// Sorted list of the nearest targets: insert with tail shift, one read port.
module nkts_slot_list
   import nkts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  slot_ctrl_type      ctrl,
   output logic [COUNT_W-1:0] count,
   output logic [ID_W-1:0]    rd_id,
   output dist_type           rd_dist
);

   logic [ID_W-1:0]    slot_id_ff   [TARGET_SLOTS];
   dist_type           slot_dist_ff [TARGET_SLOTS];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] last_pos;

   always_comb begin
      last_pos = (int'(count_ff) < TARGET_SLOTS) ? count_ff : COUNT_W'(TARGET_SLOTS - 1);
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.insert && int'(count_ff) < TARGET_SLOTS) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // each slot either takes the new point, takes its upper neighbor, or holds
   always_ff @(posedge clock) begin
      for (int i = 0; i < TARGET_SLOTS; i++) begin
         if (ctrl.insert) begin
            if (i == int'(ctrl.pos)) begin
               slot_id_ff[i]   <= ctrl.new_id;
               slot_dist_ff[i] <= ctrl.new_dist;
            end else if (i > int'(ctrl.pos) && i <= int'(last_pos) && i > 0) begin
               slot_id_ff[i]   <= slot_id_ff[i-1];
               slot_dist_ff[i] <= slot_dist_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      if (int'(ctrl.rd_idx) < TARGET_SLOTS) begin
         rd_id   = slot_id_ff[ctrl.rd_idx];
         rd_dist = slot_dist_ff[ctrl.rd_idx];
      end else begin
         rd_id   = '0;
         rd_dist = '0;
      end
   end

   assign count = count_ff;

endmodule

/* rtl/nearest_k_target_select.sv */
// Nearest-target selector top level: register port, sequencer and result register.
// Keeps up to TARGET_SLOTS candidate points nearest to the programmed origin, sorted by
// squared distance (ties keep arrival order), admitting only points within search_range
// (inclusive). A point is squared for dx, dy and range, checked, and if in range scanned
// past the stored slots not farther than it and inserted; one 16x16 squarer is used three
// times (dx, dy, range) and the list is compared one slot per cycle. The block is not
// ready while a point is being worked. On frame_last the list drains as one result item per
// cycle while the result channel accepts (a single not-found item if empty), then clears.
module nearest_k_target_select
   import nkts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   nkts_req_if.sink   req_chan,
   nkts_rsp_if.source rsp_chan,
   nkts_csr_if.sink   csr_chan
);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] ST_SQX  = 3'd1;
   localparam logic [STATE_W-1:0] ST_SQY  = 3'd2;
   localparam logic [STATE_W-1:0] ST_SQR  = 3'd3;
   localparam logic [STATE_W-1:0] ST_CHK  = 3'd4;
   localparam logic [STATE_W-1:0] ST_SCAN = 3'd5;
   localparam logic [STATE_W-1:0] ST_EMIT = 3'd6;

   logic [STATE_W-1:0] state_ff, state_in;

   logic signed [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic [RANGE_W-1:0]        range_ff;

   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [ID_W-1:0]           pid_ff;
   logic                      last_ff;
   dist_type                  dist_ff, dist_in;
   logic [COUNT_W-1:0]        pos_ff, pos_in;
   logic [COUNT_W-1:0]        emit_idx_ff, emit_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic              rsp_last_ff, rsp_last_in;

   sq_op_type     sq_op;
   dist_type      acc;
   slot_ctrl_type slot_ctrl;
   logic [COUNT_W-1:0] count;
   logic [ID_W-1:0]    rd_id;
   dist_type           rd_dist;

   logic [COORD_W:0] dx, dy, dx_neg, dy_neg;
   logic [MAG_W-1:0] mag_x, mag_y;
   logic             req_take, rsp_slot_free, emit_last;

   // register port
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         range_ff    <= RANGE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ORIGIN_X:     origin_x_ff <= csr_chan.data;
            CSR_ORIGIN_Y:     origin_y_ff <= csr_chan.data;
            CSR_SEARCH_RANGE: range_ff    <= csr_chan.data[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // coordinate differences as 16-bit magnitudes
   always_comb begin
      dx     = {px_ff[COORD_W-1], px_ff} - {origin_x_ff[COORD_W-1], origin_x_ff};
      dy     = {py_ff[COORD_W-1], py_ff} - {origin_y_ff[COORD_W-1], origin_y_ff};
      dx_neg = ~dx + 1'b1;
      dy_neg = ~dy + 1'b1;
      mag_x  = dx[COORD_W] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
      mag_y  = dy[COORD_W] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];
   end

   assign req_take       = req_chan.valid && (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign emit_last      = (count == '0) || (emit_idx_ff == count - 1'b1);

   always_comb begin
      state_in    = state_ff;
      dist_in     = dist_ff;
      pos_in      = pos_ff;
      emit_idx_in = emit_idx_ff;

      sq_op           = '0;
      slot_ctrl       = '0;
      slot_ctrl.pos    = pos_ff;
      slot_ctrl.new_id = pid_ff;
      slot_ctrl.new_dist = dist_ff;
      slot_ctrl.rd_idx = (state_ff == ST_EMIT) ? emit_idx_ff[SLOT_IDX_W-1:0]
                                               : pos_ff[SLOT_IDX_W-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.point_valid) begin
                  state_in = ST_SQX;
               end else if (req_chan.frame_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SQX: begin
            sq_op    = '{en: 1'b1, clear_acc: 1'b1, operand: mag_x};
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_op    = '{en: 1'b1, clear_acc: 1'b0, operand: mag_y};
            state_in = ST_SQR;
         end
         ST_SQR: begin
            dist_in  = acc;
            sq_op    = '{en: 1'b1, clear_acc: 1'b1, operand: MAG_W'(range_ff)};
            state_in = ST_CHK;
         end
         ST_CHK: begin
            pos_in = '0;
            if (dist_ff <= acc) begin
               state_in = ST_SCAN;
            end else begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (pos_ff < count && rd_dist <= dist_ff) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               slot_ctrl.insert = (int'(pos_ff) < TARGET_SLOTS);
               state_in         = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = (count != '0);
               rsp_id_in    = (count != '0) ? rd_id : '0;
               rsp_rank_in  = RANK_W'(emit_idx_ff);
               rsp_last_in  = emit_last;
               if (emit_last) begin
                  slot_ctrl.clear = 1'b1;
                  emit_idx_in     = '0;
                  state_in        = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_idx_ff  <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         px_ff     <= req_chan.point_x;
         py_ff     <= req_chan.point_y;
         pid_ff    <= req_chan.point_id;
         last_ff   <= req_chan.frame_last;
      end
      dist_ff      <= dist_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_last_ff  <= rsp_last_in;
   end

   nkts_sq_unit u_sq (
      .clock (clock),
      .op    (sq_op),
      .acc   (acc)
   );

   nkts_slot_list u_slots (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (slot_ctrl),
      .count   (count),
      .rd_id   (rd_id),
      .rd_dist (rd_dist)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.target_found = rsp_found_ff;
   assign rsp_chan.target_id    = rsp_id_ff;
   assign rsp_chan.target_rank  = rsp_rank_ff;
   assign rsp_chan.result_last  = rsp_last_ff;

endmodule
